// ===== sv/rlcl_pkg.sv =====
// Package with shared types and constants of the binary run-length code length meter.
`timescale 1ns / 1ps

package rlcl_pkg;

    localparam int PIXEL_W       = 8;
    localparam int LINE_BITS_W   = 14;
    localparam int TOTAL_W       = 32;
    localparam int COUNT_W_MAX   = 13;

    localparam logic [PIXEL_W-1:0]     THRESHOLD_RESET = 8'd150;
    localparam logic [LINE_BITS_W-1:0] LINE_MAX        = 14'h3FFF;
    localparam logic [TOTAL_W-1:0]     TOTAL_MAX       = 32'hFFFF_FFFF;
    localparam int                     COUNT_MAX       = 8191;

    localparam int MAX_LINE_WIDTH_DEF = 4096;
    localparam int RUN_BITS_DEF       = 16;
    localparam int QUEUE_DEPTH        = 2;

    // One binarized pixel as it travels from the front to the back.
    typedef struct packed {
        logic colour;
        logic line_end;
        logic frame_end;
    } rlcl_item_t;

    // One finished line handed to the output stage.
    typedef struct packed {
        logic                   valid;
        logic [LINE_BITS_W-1:0] line_bits;
        logic                   frame_end;
    } rlcl_line_t;

endpackage

// ===== sv/rlcl_if.sv =====
// Channel interfaces: pixel input, line result output and threshold write.
`timescale 1ns / 1ps

interface rlcl_pix_if import rlcl_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel;
    logic               line_end;
    logic               frame_end;

    modport source (output valid, output pixel, output line_end, output frame_end,
                    input ready);
    modport sink   (input valid, input pixel, input line_end, input frame_end,
                    output ready);
endinterface

interface rlcl_res_if import rlcl_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [LINE_BITS_W-1:0] line_bits;
    logic [TOTAL_W-1:0]     total_bits;
    logic                   frame_done;

    modport source (output valid, output line_bits, output total_bits,
                    output frame_done, input ready);
    modport sink   (input valid, input line_bits, input total_bits,
                    input frame_done, output ready);
endinterface

interface rlcl_cfg_if import rlcl_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] threshold;

    modport source (output valid, output threshold, input ready);
    modport sink   (input valid, input threshold, output ready);
endinterface

// ===== sv/rlcl_front.sv =====
// Front end: threshold register, pixel binarization and queue push.
`timescale 1ns / 1ps

module rlcl_front
    import rlcl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    rlcl_cfg_if.sink           cfg,
    rlcl_pix_if.sink           pixels,
    input  logic               queue_full,
    output logic               push,
    output rlcl_item_t         item
);

    logic [PIXEL_W-1:0] threshold_reg;
    logic [PIXEL_W-1:0] threshold_next;

    assign cfg.ready      = 1'b1;
    assign threshold_next = (cfg.valid) ? cfg.threshold : threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
        end
        else
        begin
            threshold_reg <= threshold_next;
        end
    end

    assign pixels.ready = !queue_full;
    assign push         = pixels.valid && !queue_full;

    // A frame end also closes the line it lands in.
    always_comb
    begin
        item.colour    = (pixels.pixel >= threshold_reg);
        item.line_end  = pixels.line_end | pixels.frame_end;
        item.frame_end = pixels.frame_end;
    end

endmodule

// ===== sv/rlcl_queue.sv =====
// Short register queue between the front end and the run tracker.
`timescale 1ns / 1ps

module rlcl_queue
    import rlcl_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH,
    parameter int WIDTH = $bits(rlcl_item_t)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign rd_data   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== sv/rlcl_back.sv =====
// Run tracker: follows colour runs and accumulates the coded bits of a line.
`timescale 1ns / 1ps

module rlcl_back
    import rlcl_pkg::*;
#(
    parameter int MAX_LINE_WIDTH = MAX_LINE_WIDTH_DEF,
    parameter int RUN_BITS       = RUN_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  rlcl_item_t item,
    output logic       pop,
    input  logic       line_ready,
    output rlcl_line_t line_out
);

    localparam int RUN_CAP_I = (MAX_LINE_WIDTH < COUNT_MAX) ? MAX_LINE_WIDTH : COUNT_MAX;
    localparam int CNT_W     = $clog2(RUN_CAP_I + 1);
    localparam int CL_W      = $clog2(2 * RUN_BITS);
    localparam int SUM_W     = LINE_BITS_W + 1;
    localparam logic [CNT_W-1:0] RUN_CAP   = CNT_W'(RUN_CAP_I);
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

    // Code length of a run: b is the bit length of len-1, clamped to [2, RUN_BITS].
    function automatic logic [CL_W-1:0] code_len(input logic [CNT_W-1:0] len);
        logic [CNT_W-1:0] v;
        int               b;
        v = (len == '0) ? '0 : len - 1'b1;
        b = 0;
        for (int i = 0; i < CNT_W; i++)
        begin
            if (v[i])
            begin
                b = i + 1;
            end
        end
        if (b < 2)
        begin
            b = 2;
        end
        if (b > RUN_BITS)
        begin
            b = RUN_BITS;
        end
        return (b == 2) ? CL_W'(3) : CL_W'(2 * b - 1);
    endfunction

    logic                   colour_reg, colour_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   line_start_reg, line_start_next;
    logic [LINE_BITS_W-1:0] line_sum_reg, line_sum_next;

    logic [LINE_BITS_W-1:0] base;
    logic [CL_W-1:0]        add_closed;
    logic [CL_W-1:0]        add_final;
    logic [SUM_W-1:0]       sum;
    logic [LINE_BITS_W-1:0] sum_sat;

    // Items without a line end never wait on the output stage.
    assign pop = item_valid && (!item.line_end || line_ready);

    always_comb
    begin
        colour_next = colour_reg;
        count_next  = count_reg;
        base        = line_sum_reg;
        add_closed  = '0;
        if (line_start_reg)
        begin
            colour_next = item.colour;
            count_next  = CNT_ONE;
            base        = LINE_BITS_W'(1);
        end
        else if (item.colour == colour_reg)
        begin
            if (count_reg < RUN_CAP)
            begin
                count_next = count_reg + 1'b1;
            end
        end
        else
        begin
            // The run that just ended is charged; the new one starts at one pixel.
            add_closed  = code_len(count_reg);
            colour_next = item.colour;
            count_next  = CNT_ONE;
        end

        add_final = item.line_end ? code_len(count_next) : '0;
        sum       = {1'b0, base} + SUM_W'(add_closed) + SUM_W'(add_final);
        sum_sat   = (sum > SUM_W'(LINE_MAX)) ? LINE_MAX : sum[LINE_BITS_W-1:0];

        line_sum_next   = sum_sat;
        line_start_next = item.line_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            colour_reg     <= 1'b0;
            count_reg      <= '0;
            line_start_reg <= 1'b1;
            line_sum_reg   <= '0;
        end
        else if (pop)
        begin
            colour_reg     <= colour_next;
            count_reg      <= count_next;
            line_start_reg <= line_start_next;
            line_sum_reg   <= line_sum_next;
        end
    end

    always_comb
    begin
        line_out.valid     = pop && item.line_end;
        line_out.line_bits = sum_sat;
        line_out.frame_end = item.frame_end;
    end

    // Inside a line the count stays within its cap.
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= RUN_CAP)
        else $error("run count above its cap");

    // A pixel that does not end its line leaves the tracker mid-line.
    a_mid_line: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !item.line_end |=> !line_start_reg && count_reg != '0)
        else $error("mid-line state lost after a pixel");

    // Mid-line, the line already carries at least its first-colour bit.
    a_sum_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        !line_start_reg |-> line_sum_reg != '0)
        else $error("line sum empty in the middle of a line");

endmodule

// ===== sv/rlcl_out.sv =====
// Output stage: frame total with saturation and the result register.
`timescale 1ns / 1ps

module rlcl_out
    import rlcl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  rlcl_line_t line_in,
    output logic       line_ready,
    rlcl_res_if.source results
);

    logic                   valid_reg, valid_next;
    logic [LINE_BITS_W-1:0] line_bits_reg;
    logic [TOTAL_W-1:0]     total_reg;
    logic                   frame_done_reg;
    logic [TOTAL_W-1:0]     frame_sum_reg, frame_sum_next;
    logic [TOTAL_W:0]       total_wide;
    logic [TOTAL_W-1:0]     total_sat;

    assign line_ready = !valid_reg || results.ready;

    always_comb
    begin
        total_wide = {1'b0, frame_sum_reg} + (TOTAL_W + 1)'(line_in.line_bits);
        total_sat  = total_wide[TOTAL_W] ? TOTAL_MAX : total_wide[TOTAL_W-1:0];

        valid_next     = valid_reg && !results.ready;
        frame_sum_next = frame_sum_reg;
        if (line_in.valid)
        begin
            valid_next     = 1'b1;
            frame_sum_next = line_in.frame_end ? '0 : total_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            frame_sum_reg <= '0;
        end
        else
        begin
            valid_reg     <= valid_next;
            frame_sum_reg <= frame_sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (line_in.valid)
        begin
            line_bits_reg  <= line_in.line_bits;
            total_reg      <= total_sat;
            frame_done_reg <= line_in.frame_end;
        end
    end

    assign results.valid      = valid_reg;
    assign results.line_bits  = line_bits_reg;
    assign results.total_bits = total_reg;
    assign results.frame_done = frame_done_reg;

endmodule

// ===== sv/binary_runlength_code_length.sv =====
// Top level of the binary run-length code length meter.
`timescale 1ns / 1ps

// Channel    Direction  Payload                                  Transfer when
// pixels     in         pixel[7:0], line_end, frame_end          valid && ready
// results    out        line_bits[13:0], total_bits[31:0],       valid && ready
//                       frame_done
// cfg        in         threshold[7:0]                           valid && ready
//
// One pixel per clock is accepted while the queue has room; the run tracker sets that rate.
// A pixel that ends a line passes the queue and then the result register on its way
// to the output, and it waits in the queue while the result register is still full.
// Reset is asynchronous and active low; the threshold returns to 150.
// A waiting result holds back only a line-ending pixel at the head of the queue;
// pixels ahead of it keep flowing, and once the two-entry queue fills the input stalls.

module binary_runlength_code_length
    import rlcl_pkg::*;
#(
    parameter int MAX_LINE_WIDTH = MAX_LINE_WIDTH_DEF,
    parameter int RUN_BITS       = RUN_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    rlcl_pix_if.sink   pixels,
    rlcl_res_if.source results,
    rlcl_cfg_if.sink   cfg
);

    // The front binarizes each pixel against the threshold and pushes the
    // colour together with its line and frame marks into the queue.
    logic       push;
    logic       queue_full;
    rlcl_item_t front_item;

    // The back pops classified pixels, tracks runs and sums code lengths.
    logic       pop;
    logic       queue_not_empty;
    rlcl_item_t back_item;

    // Finished lines go to the output stage, which keeps the frame total.
    rlcl_line_t line_done;
    logic       line_ready;

    rlcl_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .pixels     (pixels),
        .queue_full (queue_full),
        .push       (push),
        .item       (front_item)
    );

    rlcl_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH ($bits(rlcl_item_t))
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_data   (front_item),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (queue_not_empty),
        .rd_data   (back_item)
    );

    rlcl_back #(
        .MAX_LINE_WIDTH (MAX_LINE_WIDTH),
        .RUN_BITS       (RUN_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (queue_not_empty),
        .item       (back_item),
        .pop        (pop),
        .line_ready (line_ready),
        .line_out   (line_done)
    );

    rlcl_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .line_in    (line_done),
        .line_ready (line_ready),
        .results    (results)
    );

endmodule

// ===== dv/rlcl_line_bits_checker.sv =====
// Checker that predicts the coded bits of every line and compares the results.
`timescale 1ns / 1ps

module rlcl_line_bits_checker
    import rlcl_pkg::*;
#(
    parameter int MAX_LINE_WIDTH = MAX_LINE_WIDTH_DEF,
    parameter int RUN_BITS       = RUN_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    rlcl_pix_if  pixels,
    rlcl_res_if  results,
    rlcl_cfg_if  cfg,
    output int   mismatch_count,
    output int   lines_pending
);

    localparam int RUN_CAP = (MAX_LINE_WIDTH < COUNT_MAX) ? MAX_LINE_WIDTH : COUNT_MAX;

    typedef struct {
        logic [LINE_BITS_W-1:0] line_bits;
        logic [TOTAL_W-1:0]     total_bits;
        logic                   frame_done;
    } line_result_t;

    line_result_t       expected_lines[$];
    logic [PIXEL_W-1:0] threshold;
    logic               run_colour;
    int                 run_count;
    logic               line_start;
    int                 line_sum;
    logic [TOTAL_W-1:0] frame_sum;

    // Length of the code for one run: the bit length of len-1, kept within 2..RUN_BITS.
    function automatic int run_code_bits(input int run_len);
        int span;
        int b;
        span = (run_len == 0) ? 0 : run_len - 1;
        b = 0;
        for (int i = 0; i < 32; i++)
        begin
            if (span[i])
                b = i + 1;
        end
        if (b < 2)
            b = 2;
        if (b > RUN_BITS)
            b = RUN_BITS;
        return (b == 2) ? 3 : 2 * b - 1;
    endfunction

    function automatic int add_line_bits(input int acc, input int amount);
        return (acc + amount > int'(LINE_MAX)) ? int'(LINE_MAX) : acc + amount;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : predict_and_check
        logic             colour;
        logic             ends_frame;
        logic             ends_line;
        logic [TOTAL_W:0] total;
        line_result_t     want;
        if (!rst_n)
        begin
            threshold      = THRESHOLD_RESET;
            run_colour     = 1'b0;
            run_count      = 0;
            line_start     = 1'b1;
            line_sum       = 0;
            frame_sum      = '0;
            mismatch_count = 0;
            expected_lines.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                threshold = cfg.threshold;

            if (results.valid && results.ready)
            begin
                if (expected_lines.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("Unexpected line result: bits=%0d total=%0d done=%0b",
                                 results.line_bits, results.total_bits, results.frame_done);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_lines.pop_front();
                    if (results.line_bits !== want.line_bits ||
                        results.total_bits !== want.total_bits ||
                        results.frame_done !== want.frame_done)
                    begin
                        if (mismatch_count < 10)
                            $display({"Line result mismatch: expected bits=%0d total=%0d",
                                      " done=%0b, got bits=%0d total=%0d done=%0b"},
                                     want.line_bits, want.total_bits, want.frame_done,
                                     results.line_bits, results.total_bits,
                                     results.frame_done);
                        mismatch_count++;
                    end
                end
            end

            if (pixels.valid && pixels.ready)
            begin
                colour     = (pixels.pixel >= threshold);
                ends_frame = pixels.frame_end;
                ends_line  = pixels.line_end | ends_frame;

                if (line_start)
                begin
                    run_colour = colour;
                    run_count  = 1;
                    line_sum   = 1;
                end
                else if (colour == run_colour)
                begin
                    if (run_count < RUN_CAP)
                        run_count++;
                end
                else
                begin
                    line_sum   = add_line_bits(line_sum, run_code_bits(run_count));
                    run_colour = colour;
                    run_count  = 1;
                end

                if (ends_line)
                begin
                    line_sum = add_line_bits(line_sum, run_code_bits(run_count));
                    total    = {1'b0, frame_sum} + (TOTAL_W + 1)'(line_sum);
                    if (total[TOTAL_W])
                        total = {1'b0, TOTAL_MAX};
                    want.line_bits  = line_sum[LINE_BITS_W-1:0];
                    want.total_bits = total[TOTAL_W-1:0];
                    want.frame_done = ends_frame;
                    expected_lines.push_back(want);
                    line_start = 1'b1;
                    frame_sum  = ends_frame ? '0 : total[TOTAL_W-1:0];
                end
                else
                begin
                    line_start = 1'b0;
                end
            end
        end
        lines_pending = expected_lines.size();
    end

endmodule

// ===== dv/testbench.sv =====
// Top of the testbench: clock, reset, pixel and threshold stimulus, result sink and verdict.
`timescale 1ns / 1ps

module testbench;
    import rlcl_pkg::*;

    localparam int MAX_LINE_WIDTH = MAX_LINE_WIDTH_DEF;
    localparam int RUN_BITS       = RUN_BITS_DEF;

    // Settle time after a drain, long enough to let a pixel that ends no line work its
    // way through the queue and the run tracker.
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_PIXELS  = 100;

    logic clk;
    logic rst_n;

    int   sender_idle_pct;
    int   receiver_stall_pct;
    bit   hold_req;
    logic [PIXEL_W-1:0] cur_threshold;
    int   mismatch_count;
    int   lines_pending;
    int   random_sent;

    rlcl_pix_if pix_ch ();
    rlcl_res_if res_ch ();
    rlcl_cfg_if cfg_ch ();

    binary_runlength_code_length #(
        .MAX_LINE_WIDTH (MAX_LINE_WIDTH),
        .RUN_BITS       (RUN_BITS)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .pixels  (pix_ch),
        .results (res_ch),
        .cfg     (cfg_ch)
    );

    rlcl_line_bits_checker #(
        .MAX_LINE_WIDTH (MAX_LINE_WIDTH),
        .RUN_BITS       (RUN_BITS)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .pixels         (pix_ch),
        .results        (res_ch),
        .cfg            (cfg_ch),
        .mismatch_count (mismatch_count),
        .lines_pending  (lines_pending)
    );

    // Free-running clock with a 12 ns period.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Hard limit on the whole run, far beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    // Offers one pixel and returns at the clock edge where its transfer happens.
    // Before offering, the sender may stay idle for a random number of cycles.
    task automatic send_pixel(input logic [PIXEL_W-1:0] value, input logic last_in_line,
                              input logic last_in_frame);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            pix_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pix_ch.valid     <= 1'b1;
        pix_ch.pixel     <= value;
        pix_ch.line_end  <= last_in_line;
        pix_ch.frame_end <= last_in_frame;
        @(posedge clk);
        while (!pix_ch.ready)
            @(posedge clk);
    endtask

    // Picks a grey level on the requested side of the threshold. A threshold of
    // zero leaves no black levels, so every pixel is white then. Values right at
    // the threshold and at the ends of the range are favored.
    function automatic logic [PIXEL_W-1:0] pick_pixel(input logic white,
                                                      input logic [PIXEL_W-1:0] thr);
        int lo;
        int hi;
        if (thr == 0)
            white = 1'b1;
        if (white)
        begin
            lo = int'(thr);
            hi = 255;
        end
        else
        begin
            lo = 0;
            hi = int'(thr) - 1;
        end
        case ($urandom_range(3))
            0:       return white ? lo[PIXEL_W-1:0] : hi[PIXEL_W-1:0];
            1:       return white ? 8'd255 : 8'd0;
            default: return PIXEL_W'($urandom_range(hi, lo));
        endcase
    endfunction

    // Sends one line of random content. Most lines are short; a few are long
    // enough to give runs of many lengths. Some lines close the frame, some end
    // the frame without marking the line end, and a few pixels carry random
    // end flags as noise.
    task automatic send_random_line(input logic [PIXEL_W-1:0] thr);
        int   len;
        int   flip_pct;
        int   pick;
        logic white;
        logic closes_frame;
        logic broken;
        logic le_bit;
        logic fe_bit;
        pick = $urandom_range(99);
        if (pick < 82)
            len = $urandom_range(16, 1);
        else if (pick < 97)
            len = $urandom_range(100, 17);
        else
            len = $urandom_range(400, 101);
        case ($urandom_range(2))
            0:       flip_pct = 30;
            1:       flip_pct = 5;
            default: flip_pct = 1;
        endcase
        closes_frame = ($urandom_range(7) == 0);
        broken       = ($urandom_range(9) == 0);
        white        = 1'($urandom_range(1));
        for (int k = 0; k < len; k++)
        begin
            if ($urandom_range(99) < flip_pct)
                white = !white;
            le_bit = (k == len - 1);
            fe_bit = (k == len - 1) && closes_frame;
            if (broken && k == len - 1)
            begin
                le_bit = 1'b0;
                fe_bit = 1'b1;
            end
            if ($urandom_range(99) < 4)
            begin
                le_bit = 1'($urandom_range(1));
                fe_bit = ($urandom_range(3) == 0);
            end
            send_pixel(pick_pixel(white, thr), le_bit, fe_bit);
        end
        random_sent += len;
    endtask

    // Stops offering pixels and waits until every predicted line result has
    // come out, then lets the block settle.
    task automatic drain_lines();
        int waited;
        pix_ch.valid <= 1'b0;
        waited = 0;
        @(posedge clk);
        while (lines_pending != 0)
        begin
            @(posedge clk);
            waited++;
            if (waited > DRAIN_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Threshold writes only happen with the block drained.
    task automatic write_threshold(input logic [PIXEL_W-1:0] value);
        drain_lines();
        cfg_ch.valid     <= 1'b1;
        cfg_ch.threshold <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid  <= 1'b0;
        cur_threshold = value;
    endtask

    // Result sink. It stalls at random as the current phase asks, and on request
    // it holds ready low for a long stretch so that the block backs up and stops
    // taking pixels.
    initial
    begin : result_sink
        int held;
        res_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                res_ch.ready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(posedge clk);
                hold_req = 1'b0;
            end
            res_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
            @(posedge clk);
        end
    end

    // Main stimulus and verdict.
    initial
    begin : stimulus
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_req           = 1'b0;
        random_sent        = 0;
        cur_threshold      = THRESHOLD_RESET;
        rst_n              <= 1'b0;
        pix_ch.valid       <= 1'b0;
        pix_ch.pixel       <= '0;
        pix_ch.line_end    <= 1'b0;
        pix_ch.frame_end   <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.threshold   <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed lines at the reset threshold of 150, no idling on either side.
        // Single-pixel lines, black and white.
        send_pixel(8'd0, 1'b1, 1'b0);
        send_pixel(8'd255, 1'b1, 1'b0);
        // A colour change right at the threshold.
        send_pixel(8'd149, 1'b0, 1'b0);
        send_pixel(8'd150, 1'b1, 1'b0);
        // Every pixel changes colour.
        send_pixel(8'd150, 1'b0, 1'b0);
        send_pixel(8'd149, 1'b0, 1'b0);
        send_pixel(8'd151, 1'b0, 1'b0);
        send_pixel(8'd148, 1'b1, 1'b0);
        // A white run of three followed by one black pixel.
        send_pixel(8'd200, 1'b0, 1'b0);
        send_pixel(8'd201, 1'b0, 1'b0);
        send_pixel(8'd255, 1'b0, 1'b0);
        send_pixel(8'd0, 1'b1, 1'b0);
        // The frame ends without the line end flag; this still closes the line.
        send_pixel(8'd10, 1'b0, 1'b0);
        send_pixel(8'd20, 1'b0, 1'b1);
        // A single-pixel line that also ends the frame.
        send_pixel(8'd77, 1'b1, 1'b1);
        // Mixed run lengths, closing the frame with both flags.
        send_pixel(8'd255, 1'b0, 1'b0);
        send_pixel(8'd255, 1'b0, 1'b0);
        send_pixel(8'd0, 1'b0, 1'b0);
        send_pixel(8'd0, 1'b0, 1'b0);
        send_pixel(8'd0, 1'b0, 1'b0);
        send_pixel(8'd255, 1'b1, 1'b1);

        // One long black run, whose code is longer than any of the short runs above.
        for (int k = 0; k < 130; k++)
            send_pixel(8'd0, (k == 129), 1'b0);

        // Random phases. Each one sets a new threshold, the extremes among them,
        // and a new mix of sender idling and receiver stalls.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    write_threshold(8'd0);
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    write_threshold(8'd255);
                    sender_idle_pct    = 50;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    write_threshold(PIXEL_W'($urandom_range(254, 1)));
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 50;
                end
                default:
                begin
                    write_threshold(THRESHOLD_RESET);
                    sender_idle_pct    = 34;
                    receiver_stall_pct = 34;
                end
            endcase
            random_sent = 0;
            while (random_sent < PHASE_PIXELS)
                send_random_line(cur_threshold);

            if (phase == 0)
            begin
                // Back pressure: the sink holds off for a long time while short
                // lines keep coming, until the block stops accepting pixels.
                hold_req = 1'b1;
                for (int k = 0; k < 60; k++)
                    send_pixel(PIXEL_W'($urandom_range(255)), 1'b1,
                               ($urandom_range(15) == 0));
            end
        end

        drain_lines();
        if (mismatch_count == 0 && lines_pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/rlcl_pkg.sv
sv/rlcl_if.sv
sv/rlcl_front.sv
sv/rlcl_queue.sv
sv/rlcl_back.sv
sv/rlcl_out.sv
sv/binary_runlength_code_length.sv
dv/rlcl_line_bits_checker.sv
dv/testbench.sv
